FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PTD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ptd assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PTD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ptd assertion failed");

`endif

FILE: rtl/core/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// shared types and codes of the proximity trigger with debounce and cooldown
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned DIST_W = 31;
    localparam int unsigned THR_W  = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // phase codes
    localparam logic [1:0] PHASE_ARMED     = 2'd0;
    localparam logic [1:0] PHASE_DEBOUNCE  = 2'd1;
    localparam logic [1:0] PHASE_TRIGGERED = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_DELAY  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN    = 2'd3;

    // action codes
    localparam logic ACTION_POLL  = 1'b0;
    localparam logic ACTION_REARM = 1'b1;

    localparam logic [TIME_W-1:0] COOLDOWN_RESET = 32'd2000;

    typedef struct packed {
        logic              enabled;
        logic [THR_W-1:0]  threshold;
        logic [TIME_W-1:0] trig_delay;
        logic [TIME_W-1:0] cooldown_ms;
    } cfg_t;

    typedef struct packed {
        logic              action;
        logic [DIST_W-1:0] distance_mm;
        logic              distance_valid;
        logic [TIME_W-1:0] time_ms;
    } item_t;

    typedef struct packed {
        logic [1:0]        phase;
        logic [TIME_W-1:0] debounce_start;
        logic [TIME_W-1:0] cooldown_start;
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/ptd_cfg.sv
// ----------------------------------------------------------------------------
// ptd_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_cfg
    import ptd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLED:    cfg_next.enabled     = cfg_wdata[0];
                CFG_THRESHOLD:  cfg_next.threshold   = cfg_wdata[THR_W-1:0];
                CFG_TRIG_DELAY: cfg_next.trig_delay  = cfg_wdata[TIME_W-1:0];
                CFG_COOLDOWN:   cfg_next.cooldown_ms = cfg_wdata[TIME_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled     <= 1'b0;
            cfg_reg.threshold   <= '0;
            cfg_reg.trig_delay  <= '0;
            cfg_reg.cooldown_ms <= COOLDOWN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/core/ptd_step.sv
// ----------------------------------------------------------------------------
// ptd_step
// next-state and trigger decision for one request
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_step
    import ptd_pkg::*;
(
    input  wire cfg_t   cfg,
    input  wire state_t state,
    input  wire item_t  item,
    output state_t      state_next,
    output logic        fire
);

    logic              below;
    logic              at_or_above;
    logic [TIME_W-1:0] debounce_age;
    logic [TIME_W-1:0] cooldown_age;

    // wrapping differences
    assign debounce_age = item.time_ms - state.debounce_start;
    assign cooldown_age = item.time_ms - state.cooldown_start;

    assign below       = item.distance_valid &&
                         ({1'b0, item.distance_mm} < cfg.threshold);
    assign at_or_above = item.distance_valid &&
                         ({1'b0, item.distance_mm} >= cfg.threshold);

    always_comb
    begin
        state_next = state;
        fire       = 1'b0;
        if (item.action == ACTION_REARM)
        begin
            state_next.phase = PHASE_ARMED;
        end
        else if (cfg.enabled)
        begin
            unique case (state.phase)
                PHASE_DEBOUNCE:
                begin
                    if (!below)
                    begin
                        state_next.phase = PHASE_ARMED;
                    end
                    else if (debounce_age >= cfg.trig_delay)
                    begin
                        state_next.phase          = PHASE_TRIGGERED;
                        state_next.cooldown_start = item.time_ms;
                        fire                      = 1'b1;
                    end
                end
                PHASE_TRIGGERED:
                begin
                    if (at_or_above && (cooldown_age >= cfg.cooldown_ms))
                    begin
                        state_next.phase = PHASE_ARMED;
                    end
                end
                default:
                begin
                    // armed, and the unreachable code behaves as armed
                    if (below)
                    begin
                        state_next.phase          = PHASE_DEBOUNCE;
                        state_next.debounce_start = item.time_ms;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/proximity_trigger_debounce_cooldown.sv
// path: a request passes the input register, then the result register
// throughput: one request per cycle while the result side takes results,
// set by the combinational state update between input and result registers
// reset: asynchronous, active low; phase goes to armed, both start times to
// zero, configuration to its defaults, both pipeline registers empty
`default_nettype none

// ----------------------------------------------------------------------------
// proximity_trigger_debounce_cooldown
// distance threshold trigger with debounce delay and re-arm cooldown
// ----------------------------------------------------------------------------
module proximity_trigger_debounce_cooldown
    import ptd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // request channel
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  action,
    input  wire logic [DIST_W-1:0]     distance_mm,
    input  wire logic                  distance_valid,
    input  wire logic [TIME_W-1:0]     time_ms,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       trigger,
    output logic [1:0]                 mode
);

    cfg_t   cfg;

    // input register
    logic   in_vld_reg;
    item_t  item_reg;

    // machine state
    state_t state_reg;
    state_t state_next;
    logic   fire;

    // result register
    logic       out_vld_reg;
    logic       trig_reg;
    logic [1:0] mode_reg;

    logic   out_free;   // result register can take a new value
    logic   step_go;    // held request is processed this cycle

    ptd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ptd_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .fire       (fire)
    );

    assign out_free = !out_vld_reg || out_ready;
    assign step_go  = in_vld_reg && out_free;

    // a request is taken when the input register is empty or empties this cycle
    assign in_ready = !in_vld_reg || out_free;

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.action         <= action;
            item_reg.distance_mm    <= distance_mm;
            item_reg.distance_valid <= distance_valid;
            item_reg.time_ms        <= time_ms;
        end
    end

    // machine state advances only when its request moves to the result side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase          <= PHASE_ARMED;
            state_reg.debounce_start <= '0;
            state_reg.cooldown_start <= '0;
        end
        else if (step_go)
        begin
            state_reg <= state_next;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (step_go)
        begin
            trig_reg <= fire;
            mode_reg <= state_next.phase;
        end
    end

    assign out_valid = out_vld_reg;
    assign trigger   = trig_reg;
    assign mode      = mode_reg;

endmodule

`default_nettype wire

FILE: rtl/core/ptd_checker.sv
// ----------------------------------------------------------------------------
// ptd_checker
// port-level checks on the proximity trigger, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ptd_checker
    import ptd_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic                  trigger,
    input wire logic [1:0]            mode
);

    logic mode_known;

    assign mode_known = (mode == PHASE_ARMED) || (mode == PHASE_DEBOUNCE) ||
                        (mode == PHASE_TRIGGERED);

    // a trigger pulse always reports the triggered phase
    `PTD_ASSERT_NOW(a_trig_mode, clk, rst_n, out_valid && trigger, mode == PHASE_TRIGGERED)

    // the spare phase code never shows
    `PTD_ASSERT_NOW(a_mode_legal, clk, rst_n, out_valid, mode_known)

    // back-pressure only while a result is waiting to be taken
    `PTD_ASSERT_NOW(a_bp_cause, clk, rst_n, !in_ready, out_valid && !out_ready)

    // a stalled result holds
    `PTD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(trigger) && $stable(mode))

endmodule

bind proximity_trigger_debounce_cooldown ptd_checker u_ptd_checker (.*);

`default_nettype wire

FILE: tb/ptd_checker.sv
// ----------------------------------------------------------------------------
// ptd_monitor
// watches the request and result channels of the proximity trigger, keeps its
// own copy of the trigger state machine and compares every result with it
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_monitor
    import ptd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic                  action,
    input  wire logic [DIST_W-1:0]     distance_mm,
    input  wire logic                  distance_valid,
    input  wire logic [TIME_W-1:0]     time_ms,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic                  trigger,
    input  wire logic [1:0]            mode,
    output int unsigned                mismatches,
    output int unsigned                outstanding,
    output int unsigned                checked,
    output int unsigned                fired
);

    typedef struct packed {
        logic       trigger;
        logic [1:0] mode;
    } poll_result_t;

    cfg_t         settings;
    state_t       fsm;
    poll_result_t awaited_results[$];
    poll_result_t want;
    item_t        req;

    // one poll through the trigger state machine, returns the result it causes
    function automatic poll_result_t step_trigger_fsm(item_t r);
        logic              below;
        logic [TIME_W-1:0] elapsed;
        poll_result_t      res;
        below = r.distance_valid && ({1'b0, r.distance_mm} < settings.threshold);
        res.trigger = 1'b0;
        if (r.action == ACTION_REARM)
        begin
            fsm.phase = PHASE_ARMED;
        end
        else if (settings.enabled)
        begin
            case (fsm.phase)
                PHASE_DEBOUNCE:
                begin
                    elapsed = r.time_ms - fsm.debounce_start;
                    if (!below)
                    begin
                        fsm.phase = PHASE_ARMED;
                    end
                    else if (elapsed >= settings.trig_delay)
                    begin
                        fsm.phase = PHASE_TRIGGERED;
                        fsm.cooldown_start = r.time_ms;
                        res.trigger = 1'b1;
                    end
                end
                PHASE_TRIGGERED:
                begin
                    elapsed = r.time_ms - fsm.cooldown_start;
                    if (r.distance_valid && ({1'b0, r.distance_mm} >= settings.threshold)
                        && elapsed >= settings.cooldown_ms)
                    begin
                        fsm.phase = PHASE_ARMED;
                    end
                end
                default:
                begin
                    if (below)
                    begin
                        fsm.phase = PHASE_DEBOUNCE;
                        fsm.debounce_start = r.time_ms;
                    end
                end
            endcase
        end
        res.mode = fsm.phase;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settings.enabled     = 1'b0;
            settings.threshold   = '0;
            settings.trig_delay  = '0;
            settings.cooldown_ms = COOLDOWN_RESET;
            fsm                  = '0;
            awaited_results.delete();
            outstanding          = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ENABLED:    settings.enabled     = cfg_wdata[0];
                    CFG_THRESHOLD:  settings.threshold   = cfg_wdata;
                    CFG_TRIG_DELAY: settings.trig_delay  = cfg_wdata;
                    CFG_COOLDOWN:   settings.cooldown_ms = cfg_wdata;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                req = '{action, distance_mm, distance_valid, time_ms};
                awaited_results.push_back(step_trigger_fsm(req));
            end
            if (out_valid && out_ready)
            begin
                checked++;
                if (trigger)
                    fired++;
                if (awaited_results.size() == 0)
                begin
                    $error("result with no request outstanding: trigger %0d mode %0d",
                           trigger, mode);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (trigger !== want.trigger)
                    begin
                        $error("trigger: expected %0d, got %0d", want.trigger, trigger);
                        mismatches++;
                    end
                    if (mode !== want.mode)
                    begin
                        $error("mode: expected %0d, got %0d", want.mode, mode);
                        mismatches++;
                    end
                end
            end
            outstanding = awaited_results.size();
        end
    end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives polls and re-arm requests into the proximity trigger under random
// flow control and several register settings; the monitor predicts and
// compares every result, this module gives the verdict
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
    import ptd_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned RANDOM_PHASES = 9;
    localparam int unsigned PHASE_ITEMS   = 66;
    localparam int unsigned HOLD_CYCLES   = 80;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    wire logic             in_ready;
    logic                  action;
    logic [DIST_W-1:0]     distance_mm;
    logic                  distance_valid;
    logic [TIME_W-1:0]     time_ms;
    wire logic             out_valid;
    logic                  out_ready;
    wire logic             trigger;
    wire logic [1:0]       mode;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned checked;
    int unsigned fired;

    // flow control knobs shared by the sender and the receiver
    bit          gaps_on;
    bit          stall_on;
    bit          hold_req;
    int unsigned hold_left;
    int unsigned cycle_count;
    int unsigned sent;
    int unsigned settings_done;

    proximity_trigger_debounce_cooldown uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .distance_mm    (distance_mm),
        .distance_valid (distance_valid),
        .time_ms        (time_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .trigger        (trigger),
        .mode           (mode)
    );

    ptd_monitor u_monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .distance_mm    (distance_mm),
        .distance_valid (distance_valid),
        .time_ms        (time_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .trigger        (trigger),
        .mode           (mode),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .checked        (checked),
        .fired          (fired)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog: a hung handshake ends the run here
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // result side: random stalls, plus one long hold-off counted here so the
    // pipeline fills up and the request side sees in_ready drop
    initial
    begin
        out_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= !(stall_on && $urandom_range(99) < 11);
            end
        end
    end

    // plain poll request
    function automatic item_t poll_req(logic [DIST_W-1:0] d, logic v, logic [TIME_W-1:0] t);
        item_t r;
        r = '{ACTION_POLL, d, v, t};
        return r;
    endfunction

    // re-arm request; the other fields carry junk since the block ignores them
    function automatic item_t rearm_req();
        item_t r;
        r = '{ACTION_REARM, DIST_W'($urandom), 1'($urandom), TIME_W'($urandom)};
        return r;
    endfunction

    // called and returns at a falling edge; valid stays up until accepted
    task automatic send_request(item_t r);
        while (gaps_on && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        action         <= r.action;
        distance_mm    <= r.distance_mm;
        distance_valid <= r.distance_valid;
        time_ms        <= r.time_ms;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
        @(negedge clk);
    endtask

    // stop offering and wait until every result has come back
    task automatic drain();
        in_valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk);
    endtask

    // all four registers, back to back, only while the block is idle
    task automatic program_registers(bit en, logic [31:0] thr, logic [31:0] dly,
                                     logic [31:0] cd);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ENABLED;
        cfg_wdata <= ($urandom & ~32'd1) | 32'(en);
        @(negedge clk);
        cfg_index <= CFG_THRESHOLD;
        cfg_wdata <= thr;
        @(negedge clk);
        cfg_index <= CFG_TRIG_DELAY;
        cfg_wdata <= dly;
        @(negedge clk);
        cfg_index <= CFG_COOLDOWN;
        cfg_wdata <= cd;
        @(negedge clk);
        cfg_we    <= 1'b0;
        settings_done++;
    endtask

    initial
    begin
        logic [31:0]       now_ms;
        logic [31:0]       thr;
        logic [31:0]       dly;
        logic [31:0]       cd;
        logic [DIST_W-1:0] reading;
        bit                en;
        int unsigned       pick;

        // every input known from time zero
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_ENABLED;
        cfg_wdata      = '0;
        in_valid       = 1'b0;
        action         = ACTION_POLL;
        distance_mm    = '0;
        distance_valid = 1'b0;
        time_ms        = '0;
        gaps_on        = 1'b1;
        stall_on       = 1'b1;
        hold_req       = 1'b0;
        sent           = 0;
        settings_done  = 0;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults: disabled, so a poll below any threshold does nothing
        send_request(poll_req('0, 1'b1, '0));
        send_request(rearm_req());
        drain();

        // zero delay and zero cooldown
        program_registers(1'b1, 32'd1000, 32'd0, 32'd0);
        // entering debounce never fires on the same poll, even with zero delay
        send_request(poll_req(31'd999, 1'b1, 32'd0));
        send_request(poll_req(31'd999, 1'b1, 32'd0));
        // invalid reading in triggered does not re-arm
        send_request(poll_req(31'd5000, 1'b0, 32'd5));
        // distance exactly at threshold re-arms
        send_request(poll_req(31'd1000, 1'b1, 32'd5));
        send_request(poll_req(31'd0, 1'b1, 32'd10));
        // invalid reading while debouncing goes back to armed
        send_request(poll_req(31'd0, 1'b0, 32'd11));
        send_request(poll_req(31'd0, 1'b1, 32'd12));
        send_request(rearm_req());
        send_request(poll_req(31'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF));
        drain();

        // widest threshold: every valid reading is below, cooldown never ends
        program_registers(1'b1, 32'hFFFF_FFFF, 32'd10, 32'hFFFF_FFFF);
        send_request(poll_req(31'h7FFF_FFFF, 1'b1, 32'hFFFF_FFF8));
        // timestamp wraps through zero during the debounce
        send_request(poll_req(31'h7FFF_FFFF, 1'b1, 32'd1));
        send_request(poll_req(31'h7FFF_FFFF, 1'b1, 32'd2));
        send_request(poll_req(31'h7FFF_FFFF, 1'b1, 32'd3));
        drain();

        // disabled while triggered: state holds, re-arm still works
        program_registers(1'b0, 32'hFFFF_FFFF, 32'd10, 32'hFFFF_FFFF);
        send_request(poll_req(31'h7FFF_FFFF, 1'b1, 32'd4));
        send_request(rearm_req());
        send_request(poll_req(31'd0, 1'b1, 32'd5));
        drain();

        // random part: each phase picks its own register setting
        now_ms = $urandom;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            en  = 1'b1;
            thr = $urandom_range(3000, 50);
            dly = $urandom_range(50, 0);
            cd  = $urandom_range(100, 0);
            case (p)
                0: thr = 32'hFFFF_FFFF;
                1: thr = 32'd0;
                2: dly = 32'd0;
                3: begin en = 1'b0; thr = $urandom; dly = $urandom; cd = $urandom; end
                4: begin dly = 32'hFFFF_FFFF; cd = 32'd0; end
                5: cd = 32'd0;
                6: cd = 32'hFFFF_FFFF;
                7: thr = $urandom;
                default: ;
            endcase
            // one phase runs with no idling on either side
            gaps_on  = (p != 5);
            stall_on = (p != 5);
            program_registers(en, thr, dly, cd);

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // long result hold-off while requests keep coming
                if (p == 1 && k == 10)
                    hold_req = 1'b1;
                // request side pauses until the pipeline is empty
                if (p == 2 && k == 33)
                    drain();

                pick = $urandom_range(99);
                if (pick < 3)
                    now_ms = $urandom;
                else
                    now_ms = now_ms + $urandom_range(20, 0);

                // readings cluster below, at and above the threshold
                pick = $urandom_range(99);
                if (pick < 45 && thr != 0)
                    reading = DIST_W'($urandom_range(0,
                                  (thr > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : thr - 1));
                else if (pick < 55 && thr <= 32'h7FFF_FFFF)
                    reading = thr[DIST_W-1:0];
                else if (pick < 85 && thr <= 32'h7FFF_FFFF)
                    reading = DIST_W'($urandom_range(32'h7FFF_FFFF, thr));
                else
                    reading = DIST_W'($urandom);

                if ($urandom_range(99) < 4)
                    send_request(rearm_req());
                else
                    send_request(poll_req(reading, $urandom_range(99) < 90, now_ms));
            end
            drain();
        end

        wait (outstanding == 0);
        repeat (8) @(posedge clk);
        $display("covered %0d requests over %0d register settings in %0d cycles",
                 sent, settings_done, cycle_count);
        $display("%0d results compared, %0d of them trigger pulses", checked, fired);
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: proximity_trigger_debounce_cooldown.f
+incdir+rtl/core
rtl/core/ptd_pkg.sv
rtl/core/ptd_cfg.sv
rtl/core/ptd_step.sv
rtl/core/proximity_trigger_debounce_cooldown.sv
rtl/core/ptd_checker.sv
tb/ptd_checker.sv
tb/testbench.sv
